// ===== src/lpoc_pkg.sv =====
// Shared types, constants and column helpers for the line printer output canonicalizer.
`default_nettype none
package lpoc_pkg;

  localparam int unsigned ColumnBits = 16;
  localparam int unsigned CmpW       = (ColumnBits > 16) ? ColumnBits : 16;
  localparam int unsigned TabW       = ColumnBits + 2;
  localparam logic [ColumnBits-1:0] ColMax = {ColumnBits{1'b1}};

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  localparam int unsigned ModeRaw  = 0;
  localparam int unsigned ModeCaps = 1;
  localparam int unsigned ModeDrop = 2;

  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] CaseDiff = 8'h20;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChBquote = 8'h60;
  localparam logic [7:0] ChBar    = 8'h7C;
  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChCaret  = 8'h5E;

  typedef enum logic [1:0] {
    CFG_MODE,
    CFG_INDENT,
    CFG_LIMIT,
    CFG_PAGE
  } cfg_idx_e;

  typedef enum logic [3:0] {
    K_RAW,
    K_TAB,
    K_NL,
    K_FF,
    K_CR,
    K_BS,
    K_SPACE,
    K_PRINT,
    K_OVER
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  indent;
    logic [15:0] limit;
    logic [7:0]  page;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] lead;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [ColumnBits-1:0] lc;
    logic [ColumnBits-1:0] pc;
    logic                  cr;
    logic                  pr;
    logic [15:0]           lead;
  } put_res_t;

  function automatic logic [ColumnBits-1:0] sat_inc(input logic [ColumnBits-1:0] v);
    return (v == ColMax) ? v : v + 1'b1;
  endfunction

  // Places one printable character at the logical column.
  function automatic put_res_t put_char(input logic [ColumnBits-1:0] lc,
                                        input logic [ColumnBits-1:0] pc,
                                        input logic [15:0]           limit,
                                        input logic                  drop);
    put_res_t              r;
    logic [ColumnBits-1:0] p;
    r.cr   = 1'b0;
    r.pr   = 1'b0;
    r.lead = '0;
    r.lc   = sat_inc(lc);
    r.pc   = pc;
    p      = pc;
    if (!(lc < pc && drop)) begin
      if (lc < pc) begin
        r.cr = 1'b1;
        p    = '0;
      end
      r.pc = p;
      if (CmpW'(lc) < CmpW'(limit)) begin
        r.pr   = 1'b1;
        r.lead = 16'(lc - p);
        r.pc   = sat_inc(lc);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/lpoc_front.sv =====
// Front end: accepts text bytes and classifies them into queue entries.
`default_nettype none
module lpoc_front (
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic [2:0]     mode_i,
  input  wire logic           full_i,
  output logic                push_o,
  output lpoc_pkg::item_t     item_o
);
  import lpoc_pkg::*;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    logic [7:0] c;
    logic [7:0] sub;
    c   = in_byte_i;
    sub = '0;
    item_o.kind = K_PRINT;
    item_o.ch   = in_byte_i;
    if (mode_i[ModeRaw]) begin
      item_o.kind = K_RAW;
    end else begin
      if (mode_i[ModeCaps]) begin
        if (c >= ChLowA && c <= ChLowZ) begin
          c = c - CaseDiff;
        end
        case (c)
          ChLBrace: sub = ChLParen;
          ChRBrace: sub = ChRParen;
          ChBquote: sub = ChQuote;
          ChBar:    sub = ChBang;
          ChTilde:  sub = ChCaret;
          default:  sub = '0;
        endcase
      end
      item_o.ch = c;
      if (sub != 8'h00) begin
        item_o.kind = K_OVER;
        item_o.ch   = sub;
      end else begin
        case (c)
          ChTab:   item_o.kind = K_TAB;
          ChNl:    item_o.kind = K_NL;
          ChFf:    item_o.kind = K_FF;
          ChCr:    item_o.kind = K_CR;
          ChBs:    item_o.kind = K_BS;
          ChSpace: item_o.kind = K_SPACE;
          default: item_o.kind = K_PRINT;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/lpoc_fifo.sv =====
// Short queue of classified items between the front and back ends.
`default_nettype none
module lpoc_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lpoc_pkg::item_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output lpoc_pkg::item_t      data_o,
  output logic                 empty_o
);
  import lpoc_pkg::*;

  item_t              mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/lpoc_back.sv =====
// Back end: column and line state, result generation and the output buffer.
`default_nettype none
module lpoc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lpoc_pkg::cfg_t  cfg_i,
  input  wire lpoc_pkg::item_t item_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic [15:0]          lead_spaces_o,
  output logic                 last_o
);
  import lpoc_pkg::*;

  logic [ColumnBits-1:0] lc_q, lc_d, pc_q, pc_d;
  logic [7:0]            line_q, line_d;
  result_t               buf_q [MaxRes];
  result_t               buf_d [MaxRes];
  result_t               res   [MaxRes];
  logic [ResCntW-1:0]    cnt_q, cnt_d, n;
  logic                  take;

  assign out_valid_o   = (cnt_q != '0);
  assign take          = out_valid_o && !out_stall_i;
  assign out_byte_o    = buf_q[0].data;
  assign lead_spaces_o = buf_q[0].lead;
  assign last_o        = buf_q[0].last;

  // A new item is executed only when the buffer is empty or its final beat leaves now.
  assign pop_o = !empty_i && ((cnt_q == '0) || (cnt_q == ResCntW'(1) && take));

  always_comb begin
    put_res_t              p1;
    put_res_t              p2;
    logic [ColumnBits-1:0] lc2;
    logic [ColumnBits-1:0] ind;
    logic [TabW-1:0]       tx;
    logic [TabW-1:0]       tt;
    logic [7:0]            lcnt;
    logic                  isff;
    logic                  en   [MaxRes];
    result_t               cand [MaxRes];
    ind  = ColumnBits'(cfg_i.indent);
    p1   = put_char(lc_q, pc_q, cfg_i.limit, cfg_i.mode[ModeDrop]);
    lc2  = (p1.lc != '0) ? p1.lc - 1'b1 : '0;
    p2   = put_char(lc2, p1.pc, cfg_i.limit, cfg_i.mode[ModeDrop]);
    tx   = TabW'(lc_q) + TabW'(8) - TabW'(cfg_i.indent);
    tt   = {tx[TabW-1:3], 3'b000} + TabW'(cfg_i.indent);
    lcnt = (item_i.kind == K_NL) ? line_q + 1'b1 : line_q;
    isff = (item_i.kind == K_FF) || (lcnt >= cfg_i.page);
    for (int i = 0; i < MaxRes; i++) begin
      en[i]   = 1'b0;
      cand[i] = '{data: ChCr, lead: '0, last: 1'b0};
    end
    lc_d   = lc_q;
    pc_d   = pc_q;
    line_d = line_q;
    case (item_i.kind)
      K_RAW: begin
        en[1]   = 1'b1;
        cand[1] = '{data: item_i.ch, lead: '0, last: 1'b0};
      end
      K_TAB: begin
        lc_d = (tt[TabW-1:ColumnBits] != '0) ? ColMax : tt[ColumnBits-1:0];
      end
      K_NL, K_FF: begin
        pc_d   = '0;
        lc_d   = ind;
        line_d = lcnt;
        if (lcnt != 8'h00) begin
          en[1]   = 1'b1;
          cand[1] = '{data: (isff ? ChFf : ChNl), lead: '0, last: 1'b0};
          if (isff) begin
            line_d = '0;
          end
        end
      end
      K_CR: begin
        lc_d = ind;
      end
      K_BS: begin
        if (lc_q > ind) begin
          lc_d = lc_q - 1'b1;
        end
      end
      K_SPACE: begin
        lc_d = sat_inc(lc_q);
      end
      K_PRINT: begin
        en[0]   = p1.cr;
        en[1]   = p1.pr;
        cand[1] = '{data: item_i.ch, lead: p1.lead, last: 1'b0};
        lc_d    = p1.lc;
        pc_d    = p1.pc;
      end
      K_OVER: begin
        en[0]   = p1.cr;
        en[1]   = p1.pr;
        cand[1] = '{data: item_i.ch, lead: p1.lead, last: 1'b0};
        en[2]   = p2.cr;
        en[3]   = p2.pr;
        cand[3] = '{data: ChDash, lead: p2.lead, last: 1'b0};
        lc_d    = p2.lc;
        pc_d    = p2.pc;
      end
      default: begin
        lc_d = lc_q;
      end
    endcase
    // Pack the enabled results to the front and flag the final one.
    n = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = cand[i];
    end
    for (int i = 0; i < MaxRes; i++) begin
      if (en[i]) begin
        res[n[ResCntW-2:0]] = cand[i];
        n = n + 1'b1;
      end
    end
    for (int i = 0; i < MaxRes; i++) begin
      res[i].last = (ResCntW'(i) + 1'b1 == n);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxRes; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (pop_o) begin
      cnt_d = n;
      for (int i = 0; i < MaxRes; i++) begin
        buf_d[i] = res[i];
      end
    end else if (take) begin
      cnt_d = cnt_q - 1'b1;
      for (int i = 0; i < MaxRes - 1; i++) begin
        buf_d[i] = buf_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q   <= '0;
      pc_q   <= '0;
      line_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (pop_o) begin
        lc_q   <= lc_d;
        pc_q   <= pc_d;
        line_q <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_final_beat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == ResCntW'(1)) |-> buf_q[0].last)
    else $error("single buffered beat is not marked last");

  a_nonlast_has_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !buf_q[0].last) |-> (cnt_q > ResCntW'(1)))
    else $error("non-final beat has no successor in the buffer");

  a_buffer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(MaxRes))
    else $error("output buffer count out of range");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && n == '0) |=> !out_valid_o)
    else $error("item without results left beats in the buffer");
`endif

endmodule
`default_nettype wire

// ===== src/line_printer_output_canonicalizer_top.sv =====
// Top level of the line printer output canonicalizer: configuration registers and wiring.
`default_nettype none
// Converts a text byte stream into printer beats (byte plus leading space count plus
// last flag). A byte that yields zero or one beat is taken every cycle while the output
// is not stalled; a byte that yields several beats (a forced return before a character,
// or a capitals-mode overstrike, up to four beats) holds the output buffer until each
// beat is taken, and a four-entry queue behind the input keeps accepting bytes while
// that buffer drains. Each byte is registered in the queue, then in the output buffer.
// Configuration writes are always ready and must be made while the block is idle.
module line_printer_output_canonicalizer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      lead_spaces_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import lpoc_pkg::*;

  cfg_t  cfg_q;
  item_t front_item, queue_item;
  logic  push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= '0;
      cfg_q.indent <= '0;
      cfg_q.limit  <= 16'hFFFF;
      cfg_q.page   <= 8'd66;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:   cfg_q.mode   <= cfg_data_i[2:0];
        CFG_INDENT: cfg_q.indent <= cfg_data_i[7:0];
        CFG_LIMIT:  cfg_q.limit  <= cfg_data_i;
        CFG_PAGE:   cfg_q.page   <= cfg_data_i[7:0];
        default:    cfg_q.mode   <= cfg_q.mode;
      endcase
    end
  end

  lpoc_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .mode_i     (cfg_q.mode),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  lpoc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_item),
    .empty_o (empty)
  );

  lpoc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_i        (queue_item),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .lead_spaces_o (lead_spaces_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire
